[sv/wlff_pkg.sv]
package wlff_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int PAT_CHARS   = 16;
  localparam int PAT_CAP     = (MAX_PATTERN < PAT_CHARS) ? MAX_PATTERN : PAT_CHARS;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ANY  = 8'h3F;

  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_MASK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDE_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd4;

  typedef struct packed {
    logic [7:0] character;
    logic       has_char;
    logic [2:0] field_sel;
    logic       string_end;
    logic       message_end;
  } wlff_in_t;

  typedef struct packed {
    logic pass;
    logic matched;
  } wlff_out_t;

  // broadcast to every cell
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       step_en;
    logic       clr;
  } wlff_bcast_t;

  // handed from cell i to cell i+1
  typedef struct packed {
    logic fwd1;
    logic step;
    logic fwd2;
  } wlff_link_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

[sv/wlff_cell.sv]
module wlff_cell
  import wlff_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  wlff_bcast_t bc_i,
  input  logic [7:0]  pchar_i,
  input  logic        en_i,
  input  logic        keep_i,
  input  wlff_link_t  link_i,
  output wlff_link_t  link_o,
  output logic        hit_o
);

  logic act_q, act_d;
  logic star, any, c1, c2, n_bit, nxt;

  assign star = (pchar_i == CH_STAR);
  assign any  = (pchar_i == CH_ANY);

  // closure before the character, advance, closure after it
  assign c1    = (act_q & keep_i) | link_i.fwd1;
  assign n_bit = (c1 & en_i & star) | link_i.step;
  assign c2    = n_bit | link_i.fwd2;

  assign link_o.fwd1 = c1 & en_i & star;
  assign link_o.step = c1 & en_i & ~star & (any | (pchar_i == bc_i.ch));
  assign link_o.fwd2 = c2 & en_i & star;

  // final position is the one kept but not consuming
  assign hit_o = keep_i & ~en_i & (c1 | (bc_i.has_char & c2));

  assign nxt = bc_i.has_char ? c2 : c1;

  always_comb begin
    act_d = act_q;
    if (bc_i.step_en) begin
      act_d = bc_i.clr ? 1'b0 : (keep_i & nxt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

endmodule

[sv/wildcard_log_field_filter_unit.sv]
// Wildcard log field filter.
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat per text byte of
// a message's strings; has_char=0 with an end mark closes an empty string.
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i at once
// (0 field mask, 1 exclude mode, 2 pattern length, 3/4 pattern bytes);
// write only while no message is in flight.
// Output channel (out_valid_o/out_ready_i/out_data_o): one verdict beat for
// every input beat with message_end set, valid on the cycle after it.
// Throughput: one input beat per cycle unless stalled; each beat updates a row
// of MAX_PATTERN+1 position cells in that cycle, one cell per pattern position.
// Stall: the verdict sits in an output register; while it is held and the
// receiver is not ready, in_ready_o drops, otherwise input keeps flowing.
// Reset: field mask all ones, include mode, empty pattern (every message
// passes), no partial match state, output empty.
module wildcard_log_field_filter_unit
  import wlff_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wlff_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wlff_out_t            out_data_o
);

  logic [4:0]            field_mask_q;
  logic                  exclude_q;
  logic [4:0]            plen_q;
  logic [2*CFG_W-1:0]    pat_q;
  logic [LEN_W-1:0]      eff_len;

  logic                  sm_q, sm_d, mm_q, mm_d;
  logic                  out_valid_q, out_valid_d;
  wlff_out_t             out_q, out_d;

  logic                  accept, str_end, sm_n, enabled;
  logic [7:0]            mask_ext;
  wlff_bcast_t           bc;
  wlff_link_t            link [MAX_PATTERN+2];
  logic [MAX_PATTERN:0]  hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_mask_q <= 5'h1F;
      exclude_q    <= 1'b0;
      plen_q       <= '0;
      pat_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIELD_MASK:   field_mask_q       <= cfg_wdata_i[4:0];
        CFG_EXCLUDE_MODE: exclude_q          <= cfg_wdata_i[0];
        CFG_PATTERN_LEN:  plen_q             <= cfg_wdata_i[4:0];
        CFG_PATTERN_LOW:  pat_q[CFG_W-1:0]   <= cfg_wdata_i;
        CFG_PATTERN_HIGH: pat_q[2*CFG_W-1:CFG_W] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign eff_len = (plen_q > 5'(PAT_CAP)) ? LEN_W'(PAT_CAP) : LEN_W'(plen_q);

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign str_end    = in_data_i.string_end | in_data_i.message_end;

  assign bc.ch       = fold_case(in_data_i.character);
  assign bc.has_char = in_data_i.has_char;
  assign bc.step_en  = accept;
  assign bc.clr      = str_end;

  assign link[0] = '{fwd1: 1'b1, step: 1'b1, fwd2: 1'b1};

  for (genvar i = 0; i <= MAX_PATTERN; i++) begin : g_cell
    logic [7:0] pchar;
    if (i < PAT_CAP) begin : g_pat
      assign pchar = fold_case(pat_q[i*8 +: 8]);
    end else begin : g_nopat
      assign pchar = '0;
    end

    wlff_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bc_i    (bc),
      .pchar_i (pchar),
      .en_i    (eff_len > LEN_W'(i)),
      .keep_i  (eff_len >= LEN_W'(i)),
      .link_i  (link[i]),
      .link_o  (link[i+1]),
      .hit_o   (hit[i])
    );
  end

  assign sm_n     = sm_q | (|hit);
  assign mask_ext = {3'b000, field_mask_q};
  assign enabled  = mask_ext[in_data_i.field_sel];

  always_comb begin
    sm_d        = sm_q;
    mm_d        = mm_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      sm_d = sm_n;
      if (str_end) begin
        sm_d = 1'b0;
        mm_d = mm_q | (enabled & sm_n);
      end
      if (in_data_i.message_end) begin
        out_valid_d = 1'b1;
        if (eff_len == '0) begin
          out_d.pass    = 1'b1;
          out_d.matched = 1'b0;
        end else begin
          out_d.pass    = (mm_q | (enabled & sm_n)) ^ exclude_q;
          out_d.matched = mm_q | (enabled & sm_n);
        end
        mm_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_q        <= 1'b0;
      mm_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sm_q        <= sm_d;
      mm_q        <= mm_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/wlff_chk.sv]
module wlff_chk
  import wlff_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input wlff_in_t             in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input wlff_out_t            out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.message_end |=> out_valid_o)
    else $error("no verdict after message end");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && in_data_i.message_end))
    else $error("verdict without message end");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while verdict blocked");

endmodule

bind wildcard_log_field_filter_unit wlff_chk u_wlff_chk (.*);
